### src/adu_pkg.sv
// Shared constants, lane codes and table functions for the angular distance unit.
package adu_pkg;

  localparam int FRAC_BITS_DEF     = 16;
  localparam int CORDIC_STAGES_DEF = 24;

  localparam int RA_W  = 25;
  localparam int DEC_W = 24;
  localparam int SEP_W = 24;

  localparam int ANG_FRAC = 32;
  localparam int ANG_W    = 42;
  localparam int VAL_W    = 34;
  localparam int T_W      = 32;
  localparam int SQ_W     = 62;
  localparam int SQRT_STG = 31;
  localparam int Q_SH     = 30;

  localparam logic signed [VAL_W-1:0] GAIN_INV = VAL_W'(652032875);
  localparam logic [63:0] RAD_TO_DEG_Q26 = 64'd3845054675;

  localparam int LANES     = 3;
  localparam int LANE_DEC1 = 0;
  localparam int LANE_DEC2 = 1;
  localparam int LANE_DRA  = 2;

  localparam int QUEUE_DEPTH = 2;

  localparam longint IN_SPAN      = longint'(1) << RA_W;
  localparam longint FULL_RAW_DEF = longint'(360) << FRAC_BITS_DEF;
  localparam longint OFS_RAW_DEF  =
    FULL_RAW_DEF / 2 + (IN_SPAN / FULL_RAW_DEF + 1) * FULL_RAW_DEF;
  localparam longint U_MAX_DEF    = IN_SPAN + OFS_RAW_DEF;
  localparam int     RED_W_DEF    = $clog2(U_MAX_DEF + 1);
  localparam int     RED_STG_DEF  = $clog2(U_MAX_DEF / FULL_RAW_DEF + 1);

  // Long division by shift and subtract, evaluated at elaboration only.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-idx) in degrees with 32 fraction bits, from a floored Taylor series.
  function automatic logic [63:0] atan_entry(input int idx);
    logic [63:0] acc;
    logic [63:0] term;
    logic        add;
    acc = '0;
    add = 1'b1;
    if (idx == 0) begin
      return 64'd45 << ANG_FRAC;
    end
    for (int k = 1; k * idx <= 60; k += 2) begin
      term = udiv64(64'd1 << (60 - k * idx), 64'(k));
      acc  = add ? acc + term : acc - term;
      add  = !add;
    end
    return ((acc >> 28) * RAD_TO_DEG_Q26) >> 26;
  endfunction

endpackage

### src/adu_front.sv
// Input side: takes coordinate beats, offsets the three angles, and queues them.
module adu_front import adu_pkg::*; #(
  parameter int     RED_W   = RED_W_DEF,
  parameter longint OFS_RAW = OFS_RAW_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [RA_W-1:0]         first_ra_i,
  input  logic signed [DEC_W-1:0] first_dec_i,
  input  logic [RA_W-1:0]         second_ra_i,
  input  logic signed [DEC_W-1:0] second_dec_i,
  input  logic                    deq_i,
  output logic                    q_valid_o,
  output logic [RED_W-1:0]        u_o [LANES]
);

  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic signed [RED_W:0] OFS = (RED_W+1)'(OFS_RAW);

  logic signed [RA_W:0]  dra;
  logic [RED_W-1:0]      u_in [LANES];
  logic [RED_W-1:0]      mem_q [QUEUE_DEPTH][LANES];
  logic [QPTR_W-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]     cnt_q, cnt_d;
  logic                  push_ok;

  // Shift every angle positive so the back end reduces with plain subtracts.
  assign dra = $signed({1'b0, second_ra_i}) - $signed({1'b0, first_ra_i});
  assign u_in[LANE_DEC1] = RED_W'((RED_W+1)'(first_dec_i) + OFS);
  assign u_in[LANE_DEC2] = RED_W'((RED_W+1)'(second_dec_i) + OFS);
  assign u_in[LANE_DRA]  = RED_W'((RED_W+1)'(dra) + OFS);

  assign full      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign q_valid_o = (cnt_q != '0);
  assign push_ok   = push && !full;
  assign u_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_ok ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = deq_i ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push_ok) - QCNT_W'(deq_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= u_in;
    end
  end

  a_deq_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_i |-> q_valid_o)
    else $error("dequeue from empty front queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("front queue count overflow");

endmodule

### src/adu_trig.sv
// Angle reduction and rotation CORDIC: sine and cosine for three lanes.
module adu_trig import adu_pkg::*; #(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int RED_W         = RED_W_DEF,
  parameter int RED_STG       = RED_STG_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [RED_W-1:0]        u_i [LANES],
  output logic                    valid_o,
  output logic signed [VAL_W-1:0] sin_o [LANES],
  output logic signed [VAL_W-1:0] cos_o [LANES]
);

  localparam int     LAT      = RED_STG + CORDIC_STAGES + 3;
  localparam int     SHL      = ANG_FRAC - FRAC_BITS;
  localparam longint FULL_RAW = longint'(360) << FRAC_BITS;
  localparam logic [RED_W-1:0]      FULL    = RED_W'(FULL_RAW);
  localparam logic signed [RED_W:0] HALF    = (RED_W+1)'(longint'(180) << FRAC_BITS);
  localparam logic signed [RED_W:0] QUARTER = (RED_W+1)'(longint'(90) << FRAC_BITS);

  logic [LAT-1:0]            vld_q;
  logic [RED_W-1:0]          red_q [RED_STG+1][LANES];
  logic signed [RED_W:0]     wrapped [LANES];
  logic signed [RED_W:0]     folded [LANES];
  logic                      fold_flip [LANES];
  logic signed [VAL_W-1:0]   x_q [CORDIC_STAGES+1][LANES];
  logic signed [VAL_W-1:0]   y_q [CORDIC_STAGES+1][LANES];
  logic signed [ANG_W-1:0]   z_q [CORDIC_STAGES+1][LANES];
  logic                      fl_q [CORDIC_STAGES+1][LANES];
  logic signed [VAL_W-1:0]   sin_q [LANES];
  logic signed [VAL_W-1:0]   cos_q [LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q[0] <= u_i;
    end
  end

  // Modulo 360 by one conditional subtract of a scaled full turn per stage.
  for (genvar j = 1; j <= RED_STG; j++) begin : g_red
    localparam logic [RED_W-1:0] SUB = RED_W'(FULL_RAW << (RED_STG - j));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < LANES; l++) begin
          red_q[j][l] <= (red_q[j-1][l] >= SUB) ? red_q[j-1][l] - SUB : red_q[j-1][l];
        end
      end
    end
  end

  // Move into [-180,180), then fold past +-90 and remember to negate.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      wrapped[l]   = $signed({1'b0, red_q[RED_STG][l]}) - HALF;
      folded[l]    = wrapped[l];
      fold_flip[l] = 1'b0;
      if (wrapped[l] > QUARTER) begin
        folded[l]    = wrapped[l] - HALF;
        fold_flip[l] = 1'b1;
      end else if (wrapped[l] < -QUARTER) begin
        folded[l]    = wrapped[l] + HALF;
        fold_flip[l] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        x_q[0][l]  <= GAIN_INV;
        y_q[0][l]  <= '0;
        z_q[0][l]  <= ANG_W'(folded[l]) <<< SHL;
        fl_q[0][l] <= fold_flip[l];
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    localparam logic signed [ANG_W-1:0] ATAN_I = ANG_W'(atan_entry(i));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < LANES; l++) begin
          fl_q[i+1][l] <= fl_q[i][l];
          if (!z_q[i][l][ANG_W-1]) begin
            x_q[i+1][l] <= x_q[i][l] - (y_q[i][l] >>> i);
            y_q[i+1][l] <= y_q[i][l] + (x_q[i][l] >>> i);
            z_q[i+1][l] <= z_q[i][l] - ATAN_I;
          end else begin
            x_q[i+1][l] <= x_q[i][l] + (y_q[i][l] >>> i);
            y_q[i+1][l] <= y_q[i][l] - (x_q[i][l] >>> i);
            z_q[i+1][l] <= z_q[i][l] + ATAN_I;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        sin_q[l] <= fl_q[CORDIC_STAGES][l] ? -y_q[CORDIC_STAGES][l] : y_q[CORDIC_STAGES][l];
        cos_q[l] <= fl_q[CORDIC_STAGES][l] ? -x_q[CORDIC_STAGES][l] : x_q[CORDIC_STAGES][l];
      end
    end
  end

  assign valid_o = vld_q[LAT-1];
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;

  a_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[RED_STG] |-> (red_q[RED_STG][LANE_DEC1] < FULL) &&
                       (red_q[RED_STG][LANE_DEC2] < FULL) &&
                       (red_q[RED_STG][LANE_DRA] < FULL))
    else $error("angle not reduced below a full turn");

endmodule

### src/adu_acos.sv
// Law of cosines, square root and vectoring CORDIC: separation angle from trig terms.
module adu_acos import adu_pkg::*; #(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [VAL_W-1:0] sin_i [LANES],
  input  logic signed [VAL_W-1:0] cos_i [LANES],
  output logic                    valid_o,
  output logic [SEP_W-1:0]        sep_o
);

  localparam int LAT = 5 + SQRT_STG + 1 + CORDIC_STAGES + 1;
  localparam int SHR = ANG_FRAC - FRAC_BITS;
  localparam logic signed [VAL_W:0]   ONE      = (VAL_W+1)'(longint'(1) << Q_SH);
  localparam logic signed [T_W-1:0]   ONE_T    = T_W'(longint'(1) << Q_SH);
  localparam logic [SQ_W-1:0]         SQ_TOP   = SQ_W'(longint'(1) << (2 * Q_SH));
  localparam logic signed [ANG_W-1:0] HALF_ANG = ANG_W'(longint'(180) << ANG_FRAC);
  localparam logic signed [ANG_W-1:0] QTR_ANG  = ANG_W'(longint'(90) << ANG_FRAC);
  localparam logic signed [ANG_W-1:0] RND      = ANG_W'(longint'(1) << (SHR - 1));
  localparam logic [ANG_W-1:0]        LIM      = ANG_W'(longint'(180) << FRAC_BITS);

  logic [LAT-1:0]              vld_q;
  logic signed [2*VAL_W-1:0]   prod_ss, prod_cc, prod_cd;
  logic signed [VAL_W-1:0]     p1_q, p2_q, cd_q, p1b_q, p3_q;
  logic signed [VAL_W:0]       tsum;
  logic signed [T_W-1:0]       t_q, t4_q;
  logic signed [2*T_W-1:0]     tt;
  logic [SQ_W-1:0]             tt_q;
  logic [SQ_W-1:0]             rem_q [SQRT_STG+1];
  logic [SQ_W-1:0]             root_q [SQRT_STG+1];
  logic signed [T_W-1:0]       ts_q [SQRT_STG+1];
  logic signed [VAL_W-1:0]     y_root, x_t;
  logic signed [VAL_W-1:0]     x_q [CORDIC_STAGES+1];
  logic signed [VAL_W-1:0]     y_q [CORDIC_STAGES+1];
  logic signed [ANG_W-1:0]     z_q [CORDIC_STAGES+1];
  logic signed [ANG_W-1:0]     z_fin, z_clip;
  logic [ANG_W-1:0]            rounded;
  logic [SEP_W-1:0]            sep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[LAT-2:0], valid_i};
    end
  end

  assign prod_ss = sin_i[LANE_DEC1] * sin_i[LANE_DEC2];
  assign prod_cc = cos_i[LANE_DEC1] * cos_i[LANE_DEC2];
  assign prod_cd = p2_q * cd_q;
  assign tsum    = p1b_q + p3_q;
  assign tt      = t_q * t_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q  <= VAL_W'(prod_ss >>> Q_SH);
      p2_q  <= VAL_W'(prod_cc >>> Q_SH);
      cd_q  <= cos_i[LANE_DRA];
      p1b_q <= p1_q;
      p3_q  <= VAL_W'(prod_cd >>> Q_SH);
      // Clamp the cosine to [-1,1] so the root below stays real.
      if (tsum > ONE) begin
        t_q <= ONE_T;
      end else if (tsum < -ONE) begin
        t_q <= -ONE_T;
      end else begin
        t_q <= T_W'(tsum);
      end
      tt_q      <= SQ_W'(tt);
      t4_q      <= t_q;
      rem_q[0]  <= SQ_TOP - tt_q;
      root_q[0] <= '0;
      ts_q[0]   <= t4_q;
    end
  end

  // Integer square root, one result bit per stage.
  for (genvar k = 0; k < SQRT_STG; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STG - 1 - k));
    logic [SQ_W-1:0] trial;
    assign trial = root_q[k] + BIT;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ts_q[k+1] <= ts_q[k];
        if (rem_q[k] >= trial) begin
          rem_q[k+1]  <= rem_q[k] - trial;
          root_q[k+1] <= (root_q[k] >> 1) + BIT;
        end else begin
          rem_q[k+1]  <= rem_q[k];
          root_q[k+1] <= root_q[k] >> 1;
        end
      end
    end
  end

  assign y_root = VAL_W'(root_q[SQRT_STG]);
  assign x_t    = VAL_W'(ts_q[SQRT_STG]);

  // Rotate a negative cosine by a quarter turn to keep the vector in range.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (x_t[VAL_W-1]) begin
        x_q[0] <= y_root;
        y_q[0] <= -x_t;
        z_q[0] <= QTR_ANG;
      end else begin
        x_q[0] <= x_t;
        y_q[0] <= y_root;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    localparam logic signed [ANG_W-1:0] ATAN_I = ANG_W'(atan_entry(i));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_q[i][VAL_W-1]) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ATAN_I;
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ATAN_I;
        end
      end
    end
  end

  always_comb begin
    z_fin = z_q[CORDIC_STAGES];
    if (z_fin[ANG_W-1]) begin
      z_clip = '0;
    end else if (z_fin > HALF_ANG) begin
      z_clip = HALF_ANG;
    end else begin
      z_clip = z_fin;
    end
    rounded = ANG_W'($unsigned(z_clip + RND) >> SHR);
    if (rounded > LIM) begin
      rounded = LIM;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sep_q <= SEP_W'(rounded);
    end
  end

  assign valid_o = vld_q[LAT-1];
  assign sep_o   = sep_q;

  a_t_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (t_q <= ONE_T) && (t_q >= -ONE_T))
    else $error("cosine term outside [-1,1] after clamp");

endmodule

### src/angular_distance_unit_core.sv
// Top level of the angular distance unit: front queue, trig and acos pipes, result register.
//
//   channel  | handshake          | fields
//   ---------+--------------------+----------------------------------------------------
//   input    | push / full        | first_ra_i, first_dec_i, second_ra_i, second_dec_i
//   result   | empty / pop        | separation_o
//
// One coordinate pair enters per cycle and one result leaves per cycle while each result
// is popped as it shows; an unpopped result holds the flow. An accepted pair passes
// through the reduction subtract stages, both CORDIC pipes and the one-bit-per-stage
// square root before its result shows.
// Reset clears the valid bits and the queue pointers; no state survives between pairs.
// While a result waits unpopped the pipes hold, and the two-entry front queue fills
// before full rises.
module angular_distance_unit_core import adu_pkg::*; #(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [RA_W-1:0]         first_ra_i,
  input  logic signed [DEC_W-1:0] first_dec_i,
  input  logic [RA_W-1:0]         second_ra_i,
  input  logic signed [DEC_W-1:0] second_dec_i,
  output logic                    empty,
  input  logic                    pop,
  output logic [SEP_W-1:0]        separation_o
);

  localparam longint FULL_RAW = longint'(360) << FRAC_BITS;
  localparam longint OFS_RAW  = FULL_RAW / 2 + (IN_SPAN / FULL_RAW + 1) * FULL_RAW;
  localparam longint U_MAX    = IN_SPAN + OFS_RAW;
  localparam int     RED_W    = $clog2(U_MAX + 1);
  localparam int     RED_STG  = $clog2(U_MAX / FULL_RAW + 1);
  localparam logic [SEP_W-1:0] LIM = SEP_W'(longint'(180) << FRAC_BITS);

  logic                    adv;
  logic                    q_valid, deq;
  logic [RED_W-1:0]        u [LANES];
  logic                    trig_valid, acos_valid;
  logic signed [VAL_W-1:0] sin_v [LANES];
  logic signed [VAL_W-1:0] cos_v [LANES];
  logic [SEP_W-1:0]        sep;
  logic                    out_valid_q;
  logic [SEP_W-1:0]        res_q;

  // Advance the back end whenever the result register is free or being drained.
  assign adv = !out_valid_q || pop;
  assign deq = adv && q_valid;

  adu_front #(
    .RED_W   (RED_W),
    .OFS_RAW (OFS_RAW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .first_ra_i   (first_ra_i),
    .first_dec_i  (first_dec_i),
    .second_ra_i  (second_ra_i),
    .second_dec_i (second_dec_i),
    .deq_i        (deq),
    .q_valid_o    (q_valid),
    .u_o          (u)
  );

  adu_trig #(
    .FRAC_BITS     (FRAC_BITS),
    .CORDIC_STAGES (CORDIC_STAGES),
    .RED_W         (RED_W),
    .RED_STG       (RED_STG)
  ) u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (q_valid),
    .u_i     (u),
    .valid_o (trig_valid),
    .sin_o   (sin_v),
    .cos_o   (cos_v)
  );

  adu_acos #(
    .FRAC_BITS     (FRAC_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_acos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (trig_valid),
    .sin_i   (sin_v),
    .cos_i   (cos_v),
    .valid_o (acos_valid),
    .sep_o   (sep)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= acos_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= sep;
    end
  end

  assign empty        = !out_valid_q;
  assign separation_o = res_q;

  a_sep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> separation_o <= LIM)
    else $error("separation beyond half a turn");

endmodule
